[src/segment_crossing_classify_defines.svh]
// ----------------------------------------------------------------------------
// Segment crossing classifier assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_CROSSING_CLASSIFY_DEFINES_SVH
`define SEGMENT_CROSSING_CLASSIFY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("segment_crossing_classify: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SCC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("segment_crossing_classify: next-cycle check failed");

`endif

[src/scc_pkg.sv]
// ----------------------------------------------------------------------------
// Segment crossing classifier package
// Widths, register map constants and the result class codes.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

	localparam int SCC_COORD_BITS = 24;
	localparam int SCC_TOL_BITS   = 51;
	localparam int SCC_CLASS_BITS = 2;

	// Configuration port: one 64-bit register at byte address 0.
	localparam int SCC_ADDR_BITS  = 4;
	localparam int SCC_DATA_BITS  = 64;
	localparam int SCC_REG_LSB    = 3;

	typedef enum logic [0:0] {
		REG_COLLINEAR_TOL = 1'b0
	} scc_reg_t;

	typedef enum logic [SCC_CLASS_BITS-1:0] {
		CLS_COLLINEAR    = 2'd0,
		CLS_PARALLEL     = 2'd1,
		CLS_CROSSING     = 2'd2,
		CLS_NOT_CROSSING = 2'd3
	} crossing_class_t;

endpackage

`default_nettype wire

[src/scc_intf.sv]
// ----------------------------------------------------------------------------
// Segment crossing classifier channel interfaces
// Valid/ready channels for segment pair beats and class result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface scc_seg_if #(
	parameter int COORD_BITS = 24
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] a_org_x;
	logic signed [COORD_BITS-1:0] a_org_y;
	logic signed [COORD_BITS-1:0] a_dst_x;
	logic signed [COORD_BITS-1:0] a_dst_y;
	logic signed [COORD_BITS-1:0] b_org_x;
	logic signed [COORD_BITS-1:0] b_org_y;
	logic signed [COORD_BITS-1:0] b_dst_x;
	logic signed [COORD_BITS-1:0] b_dst_y;

	modport source (
		output valid, a_org_x, a_org_y, a_dst_x, a_dst_y,
		       b_org_x, b_org_y, b_dst_x, b_dst_y,
		input  ready
	);
	modport sink (
		input  valid, a_org_x, a_org_y, a_dst_x, a_dst_y,
		       b_org_x, b_org_y, b_dst_x, b_dst_y,
		output ready
	);
endinterface

interface scc_cls_if import scc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [SCC_CLASS_BITS-1:0] crossing_class;

	modport source (output valid, crossing_class, input ready);
	modport sink (input valid, crossing_class, output ready);
endinterface

`default_nettype wire

[src/scc_delta.sv]
// ----------------------------------------------------------------------------
// Segment crossing classifier stage 1
// Forms the direction vectors of A and B and the offset of B's origin.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_delta #(
	parameter int COORD_BITS = 24
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         in_valid,
	input  wire logic signed [COORD_BITS-1:0] a_org_x,
	input  wire logic signed [COORD_BITS-1:0] a_org_y,
	input  wire logic signed [COORD_BITS-1:0] a_dst_x,
	input  wire logic signed [COORD_BITS-1:0] a_dst_y,
	input  wire logic signed [COORD_BITS-1:0] b_org_x,
	input  wire logic signed [COORD_BITS-1:0] b_org_y,
	input  wire logic signed [COORD_BITS-1:0] b_dst_x,
	input  wire logic signed [COORD_BITS-1:0] b_dst_y,
	output logic                              valid_s1,
	output logic signed [COORD_BITS:0]        dax_s1,
	output logic signed [COORD_BITS:0]        day_s1,
	output logic signed [COORD_BITS:0]        dbx_s1,
	output logic signed [COORD_BITS:0]        dby_s1,
	output logic signed [COORD_BITS:0]        ex_s1,
	output logic signed [COORD_BITS:0]        ey_s1
);

	localparam int DW = COORD_BITS + 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dax_s1 <= DW'(a_dst_x) - DW'(a_org_x);
			day_s1 <= DW'(a_dst_y) - DW'(a_org_y);
			dbx_s1 <= DW'(b_dst_x) - DW'(b_org_x);
			dby_s1 <= DW'(b_dst_y) - DW'(b_org_y);
			ex_s1  <= DW'(b_org_x) - DW'(a_org_x);
			ey_s1  <= DW'(b_org_y) - DW'(a_org_y);
		end
	end

endmodule

`default_nettype wire

[src/scc_mul.sv]
// ----------------------------------------------------------------------------
// Segment crossing classifier stage 2
// Six parallel signed products that feed the three cross products.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_mul #(
	parameter int COORD_BITS = 24
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic                           valid_s1,
	input  wire logic signed [COORD_BITS:0]     dax_s1,
	input  wire logic signed [COORD_BITS:0]     day_s1,
	input  wire logic signed [COORD_BITS:0]     dbx_s1,
	input  wire logic signed [COORD_BITS:0]     dby_s1,
	input  wire logic signed [COORD_BITS:0]     ex_s1,
	input  wire logic signed [COORD_BITS:0]     ey_s1,
	output logic                                valid_s2,
	output logic signed [2*COORD_BITS+1:0]      dbx_day_s2,
	output logic signed [2*COORD_BITS+1:0]      dby_dax_s2,
	output logic signed [2*COORD_BITS+1:0]      dax_ey_s2,
	output logic signed [2*COORD_BITS+1:0]      day_ex_s2,
	output logic signed [2*COORD_BITS+1:0]      dbx_ey_s2,
	output logic signed [2*COORD_BITS+1:0]      dby_ex_s2
);

	localparam int PW = 2 * COORD_BITS + 2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dbx_day_s2 <= PW'(dbx_s1) * PW'(day_s1);
			dby_dax_s2 <= PW'(dby_s1) * PW'(dax_s1);
			dax_ey_s2  <= PW'(dax_s1) * PW'(ey_s1);
			day_ex_s2  <= PW'(day_s1) * PW'(ex_s1);
			dbx_ey_s2  <= PW'(dbx_s1) * PW'(ey_s1);
			dby_ex_s2  <= PW'(dby_s1) * PW'(ex_s1);
		end
	end

endmodule

`default_nettype wire

[src/scc_cross.sv]
// ----------------------------------------------------------------------------
// Segment crossing classifier stage 3
// Denominator and the two parameter numerators as exact cross products.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_cross #(
	parameter int COORD_BITS = 24
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic                           valid_s2,
	input  wire logic signed [2*COORD_BITS+1:0] dbx_day_s2,
	input  wire logic signed [2*COORD_BITS+1:0] dby_dax_s2,
	input  wire logic signed [2*COORD_BITS+1:0] dax_ey_s2,
	input  wire logic signed [2*COORD_BITS+1:0] day_ex_s2,
	input  wire logic signed [2*COORD_BITS+1:0] dbx_ey_s2,
	input  wire logic signed [2*COORD_BITS+1:0] dby_ex_s2,
	output logic                                valid_s3,
	output logic signed [2*COORD_BITS+2:0]      den_s3,
	output logic signed [2*COORD_BITS+2:0]      s_num_s3,
	output logic signed [2*COORD_BITS+2:0]      t_num_s3
);

	localparam int XW = 2 * COORD_BITS + 3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s3   <= XW'(dbx_day_s2) - XW'(dby_dax_s2);
			s_num_s3 <= XW'(dax_ey_s2) - XW'(day_ex_s2);
			t_num_s3 <= XW'(dbx_ey_s2) - XW'(dby_ex_s2);
		end
	end

endmodule

`default_nettype wire

[src/scc_decide.sv]
// ----------------------------------------------------------------------------
// Segment crossing classifier stage 4
// Tolerance test for parallel pairs and unit range tests for skew pairs.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_decide
	import scc_pkg::*;
#(
	parameter int COORD_BITS = 24
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic                           valid_s3,
	input  wire logic signed [2*COORD_BITS+2:0] den_s3,
	input  wire logic signed [2*COORD_BITS+2:0] s_num_s3,
	input  wire logic signed [2*COORD_BITS+2:0] t_num_s3,
	input  wire logic        [SCC_TOL_BITS-1:0] tol,
	input  wire logic signed [SCC_TOL_BITS:0]   neg_tol,
	output logic                                valid_s4,
	output crossing_class_t                     class_s4
);

	localparam int XW = 2 * COORD_BITS + 3;
	localparam int TW = SCC_TOL_BITS + 1;
	localparam int CW = (XW > TW) ? XW : TW;

	logic signed [CW-1:0] s_ext;
	logic signed [CW-1:0] tol_ext;
	logic signed [CW-1:0] neg_tol_ext;
	logic                 den_zero;
	logic                 den_pos;
	logic                 off_line;
	logic                 s_inside;
	logic                 t_inside;
	crossing_class_t      class_d;

	always_comb begin
		s_ext       = CW'(s_num_s3);
		tol_ext     = $signed(CW'({1'b0, tol}));
		neg_tol_ext = CW'(neg_tol);
		den_zero    = (den_s3 == '0);
		den_pos     = !den_s3[XW-1] && !den_zero;
		// |s| > tol, written as two compares against the stored bounds.
		off_line    = (s_ext > tol_ext) || (s_ext < neg_tol_ext);
		if (den_pos) begin
			s_inside = !s_num_s3[XW-1] && (s_num_s3 <= den_s3);
			t_inside = !t_num_s3[XW-1] && (t_num_s3 <= den_s3);
		end else begin
			s_inside = (s_num_s3 <= 0) && (s_num_s3 >= den_s3);
			t_inside = (t_num_s3 <= 0) && (t_num_s3 >= den_s3);
		end
		if (den_zero) begin
			class_d = off_line ? CLS_PARALLEL : CLS_COLLINEAR;
		end else begin
			class_d = (s_inside && t_inside) ? CLS_CROSSING : CLS_NOT_CROSSING;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			class_s4 <= class_d;
		end
	end

endmodule

`default_nettype wire

[src/segment_crossing_classify.sv]
// ----------------------------------------------------------------------------
// Segment crossing classifier
// Classifies a pair of 2D segments as collinear, parallel, crossing or not.
// ----------------------------------------------------------------------------
// Usage:
// seg_in carries one beat per segment pair: origin and destination of A and
// of B, each coordinate COORD_BITS wide, signed. cls_out carries one beat per
// pair with the crossing class. A beat moves when valid and ready are high.
// The work runs through four register stages: direction vectors, six
// products, three cross products, then the class decision. The accepting
// edge loads the first stage; the beat then passes the second, third and
// fourth stage registers to cls_out.valid. While no stage stalls, one pair
// is accepted every cycle. Each stage advances when it is empty or when the
// stage after it moves, so a stalled receiver holds the result in the last
// stage while empty stages ahead of it keep filling; seg_in.ready drops only
// when all four are full. Reset empties the pipeline and clears the
// collinear tolerance to zero. The user must write the tolerance over the
// APB port at address 0 only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

`include "segment_crossing_classify_defines.svh"

module segment_crossing_classify
	import scc_pkg::*;
#(
	parameter int COORD_BITS = SCC_COORD_BITS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	scc_seg_if.sink                       seg_in,
	scc_cls_if.source                     cls_out,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [SCC_ADDR_BITS-1:0] paddr,
	input  wire logic [SCC_DATA_BITS-1:0] pwdata,
	output logic      [SCC_DATA_BITS-1:0] prdata,
	output logic                          pready
);

	localparam int XW = 2 * COORD_BITS + 3;
	localparam int PW = 2 * COORD_BITS + 2;

	// Configuration: the tolerance and its negation, both kept in registers
	// so the decision stage compares directly against them.
	logic        [SCC_TOL_BITS-1:0] tol_q;
	logic signed [SCC_TOL_BITS:0]   neg_tol_q;
	logic                           cfg_write;
	scc_reg_t                       reg_sel;

	assign pready    = 1'b1;
	assign reg_sel   = scc_reg_t'(paddr[SCC_ADDR_BITS-1:SCC_REG_LSB]);
	assign cfg_write = psel && penable && pwrite && pready && (reg_sel == REG_COLLINEAR_TOL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q     <= '0;
			neg_tol_q <= '0;
		end else if (cfg_write) begin
			tol_q     <= pwdata[SCC_TOL_BITS-1:0];
			neg_tol_q <= -$signed({1'b0, pwdata[SCC_TOL_BITS-1:0]});
		end
	end

	always_comb begin
		case (reg_sel)
			REG_COLLINEAR_TOL: prdata = SCC_DATA_BITS'(tol_q);
			default:           prdata = '0;
		endcase
	end

	// Stage advance chain: a stage loads when it holds nothing or when the
	// stage after it is moving on.
	logic en1, en2, en3, en4;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	assign en4          = !valid_s4 || cls_out.ready;
	assign en3          = !valid_s3 || en4;
	assign en2          = !valid_s2 || en3;
	assign en1          = !valid_s1 || en2;
	assign seg_in.ready = en1;

	logic signed [COORD_BITS:0] dax_s1, day_s1, dbx_s1, dby_s1, ex_s1, ey_s1;
	logic signed [PW-1:0]       dbx_day_s2, dby_dax_s2, dax_ey_s2;
	logic signed [PW-1:0]       day_ex_s2, dbx_ey_s2, dby_ex_s2;
	logic signed [XW-1:0]       den_s3, s_num_s3, t_num_s3;
	crossing_class_t            class_s4;

	scc_delta #(.COORD_BITS(COORD_BITS)) u_delta (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en1),
		.in_valid (seg_in.valid),
		.a_org_x  (seg_in.a_org_x),
		.a_org_y  (seg_in.a_org_y),
		.a_dst_x  (seg_in.a_dst_x),
		.a_dst_y  (seg_in.a_dst_y),
		.b_org_x  (seg_in.b_org_x),
		.b_org_y  (seg_in.b_org_y),
		.b_dst_x  (seg_in.b_dst_x),
		.b_dst_y  (seg_in.b_dst_y),
		.valid_s1 (valid_s1),
		.dax_s1   (dax_s1),
		.day_s1   (day_s1),
		.dbx_s1   (dbx_s1),
		.dby_s1   (dby_s1),
		.ex_s1    (ex_s1),
		.ey_s1    (ey_s1)
	);

	scc_mul #(.COORD_BITS(COORD_BITS)) u_mul (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en2),
		.valid_s1   (valid_s1),
		.dax_s1     (dax_s1),
		.day_s1     (day_s1),
		.dbx_s1     (dbx_s1),
		.dby_s1     (dby_s1),
		.ex_s1      (ex_s1),
		.ey_s1      (ey_s1),
		.valid_s2   (valid_s2),
		.dbx_day_s2 (dbx_day_s2),
		.dby_dax_s2 (dby_dax_s2),
		.dax_ey_s2  (dax_ey_s2),
		.day_ex_s2  (day_ex_s2),
		.dbx_ey_s2  (dbx_ey_s2),
		.dby_ex_s2  (dby_ex_s2)
	);

	scc_cross #(.COORD_BITS(COORD_BITS)) u_cross (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en3),
		.valid_s2   (valid_s2),
		.dbx_day_s2 (dbx_day_s2),
		.dby_dax_s2 (dby_dax_s2),
		.dax_ey_s2  (dax_ey_s2),
		.day_ex_s2  (day_ex_s2),
		.dbx_ey_s2  (dbx_ey_s2),
		.dby_ex_s2  (dby_ex_s2),
		.valid_s3   (valid_s3),
		.den_s3     (den_s3),
		.s_num_s3   (s_num_s3),
		.t_num_s3   (t_num_s3)
	);

	scc_decide #(.COORD_BITS(COORD_BITS)) u_decide (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en4),
		.valid_s3 (valid_s3),
		.den_s3   (den_s3),
		.s_num_s3 (s_num_s3),
		.t_num_s3 (t_num_s3),
		.tol      (tol_q),
		.neg_tol  (neg_tol_q),
		.valid_s4 (valid_s4),
		.class_s4 (class_s4)
	);

	assign cls_out.valid          = valid_s4;
	assign cls_out.crossing_class = class_s4;

	// An empty first stage must always be able to take a beat.
	`SCC_ASSERT_SAME(a_ready_when_s1_empty, !valid_s1, seg_in.ready)
	// An accepted beat always lands in the first stage.
	`SCC_ASSERT_NEXT(a_accept_fills_s1, seg_in.valid && seg_in.ready, valid_s1)
	// Back pressure reaches the input only when every stage is occupied.
	`SCC_ASSERT_SAME(a_stall_only_when_full, !seg_in.ready,
		valid_s1 && valid_s2 && valid_s3 && valid_s4 && !cls_out.ready)
	// The stored negated tolerance always tracks the last write.
	`SCC_ASSERT_NEXT(a_neg_tol_tracks, cfg_write,
		neg_tol_q == -$signed({1'b0, $past(pwdata[SCC_TOL_BITS-1:0])}))

endmodule

`default_nettype wire

[tb/segment_crossing_classify_checker.sv]
// ----------------------------------------------------------------------------
// Segment crossing classifier checker
// Watches both channels and the APB port, computes the expected crossing
// class of every accepted segment pair and compares each result beat with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_crossing_classify_checker
	import scc_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	scc_seg_if                            seg,
	scc_cls_if                            cls,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic                     pready,
	input  wire logic [SCC_ADDR_BITS-1:0] paddr,
	input  wire logic [SCC_DATA_BITS-1:0] pwdata,
	output int                            mismatches,
	output int                            awaited
);

	typedef logic signed [SCC_COORD_BITS-1:0] coord_t;

	logic [SCC_TOL_BITS-1:0] tolerance = '0;
	crossing_class_t         class_queue[$];
	int                      fail_count = 0;
	int                      pending_count = 0;

	assign mismatches = fail_count;
	assign awaited    = pending_count;

	// True when num/den lies in the closed range [0,1]; den is never zero here.
	function automatic bit in_unit_range(input longint num, input longint den);
		if (den > 0) begin
			return num >= 0 && num <= den;
		end
		return num <= 0 && num >= den;
	endfunction

	function automatic crossing_class_t classify_pair(
		input coord_t aox, input coord_t aoy, input coord_t adx, input coord_t ady,
		input coord_t box, input coord_t boy, input coord_t bdx, input coord_t bdy,
		input logic [SCC_TOL_BITS-1:0] tol
	);
		longint          dax, day, dbx, dby, ex, ey;
		longint          den, s_num, t_num;
		longint unsigned s_mag;
		crossing_class_t verdict;
		dax = longint'(adx) - longint'(aox);
		day = longint'(ady) - longint'(aoy);
		dbx = longint'(bdx) - longint'(box);
		dby = longint'(bdy) - longint'(boy);
		ex  = longint'(box) - longint'(aox);
		ey  = longint'(boy) - longint'(aoy);
		den   = dbx * day - dby * dax;
		s_num = dax * ey - day * ex;
		if (den == 0) begin
			// Parallel directions: the offset of B's origin from line A decides.
			s_mag   = (s_num < 0) ? -s_num : s_num;
			verdict = (s_mag > tol) ? CLS_PARALLEL : CLS_COLLINEAR;
		end else begin
			t_num   = dbx * ey - dby * ex;
			verdict = (in_unit_range(s_num, den) && in_unit_range(t_num, den)) ?
				CLS_CROSSING : CLS_NOT_CROSSING;
		end
		return verdict;
	endfunction

	always @(posedge clk or negedge arst_n) begin : score
		crossing_class_t want;
		if (!arst_n) begin
			tolerance <= '0;
			class_queue.delete();
			pending_count = 0;
		end else begin
			if (cls.valid && cls.ready) begin
				if (class_queue.size() == 0) begin
					$display("%0t: crossing_class beat with no pair outstanding, expected nothing, got %0d",
						$time, cls.crossing_class);
					fail_count++;
				end else begin
					want = class_queue.pop_front();
					if (cls.crossing_class !== want) begin
						$display("%0t: crossing_class mismatch, expected %0d (%s), got %0d",
							$time, want, want.name(), cls.crossing_class);
						fail_count++;
					end
				end
			end
			if (seg.valid && seg.ready) begin
				class_queue = {class_queue, classify_pair(seg.a_org_x, seg.a_org_y,
					seg.a_dst_x, seg.a_dst_y, seg.b_org_x, seg.b_org_y, seg.b_dst_x,
					seg.b_dst_y, tolerance)};
			end
			if (psel && penable && pwrite && pready &&
				scc_reg_t'(paddr[SCC_ADDR_BITS-1:SCC_REG_LSB]) == REG_COLLINEAR_TOL) begin
				tolerance <= pwdata[SCC_TOL_BITS-1:0];
			end
			pending_count = class_queue.size();
		end
	end

endmodule

[tb/segment_crossing_classify_test.sv]
// ----------------------------------------------------------------------------
// Segment crossing classifier testbench
// Drives segment pairs and tolerance writes into the classifier, with random
// idle bursts on both channels, a long receiver hold-off and drain pauses.
// The checker beside the block predicts every class; this module gives the
// verdict from its failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_crossing_classify_test;
	import scc_pkg::*;

	typedef logic signed [SCC_COORD_BITS-1:0] coord_t;

	// One segment pair as it travels on the input channel.
	typedef struct {
		coord_t a_org_x;
		coord_t a_org_y;
		coord_t a_dst_x;
		coord_t a_dst_y;
		coord_t b_org_x;
		coord_t b_org_y;
		coord_t b_dst_x;
		coord_t b_dst_y;
	} seg_pair_t;

	// The slowest correct run covers roughly 760 beats, each with its idle and
	// stall bursts and its pipeline passage, plus the hold-off and drains.
	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 200;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_PAIRS  = 150;

	localparam int COORD_LO = -(1 << (SCC_COORD_BITS - 1));
	localparam int COORD_HI = (1 << (SCC_COORD_BITS - 1)) - 1;

	// Register 0 is the tolerance; index 1 decodes to nothing.
	localparam int UNMAPPED_REG = 1;
	localparam logic [SCC_ADDR_BITS-1:0] TOL_ADDR =
		SCC_ADDR_BITS'(REG_COLLINEAR_TOL) << SCC_REG_LSB;
	localparam logic [SCC_ADDR_BITS-1:0] UNMAPPED_ADDR =
		SCC_ADDR_BITS'(UNMAPPED_REG) << SCC_REG_LSB;
	localparam logic [SCC_DATA_BITS-1:0] TOL_MAX = {SCC_TOL_BITS{1'b1}};
	// Low bits give 0x1000, everything above the register width is set.
	localparam logic [SCC_DATA_BITS-1:0] TOL_WITH_EXCESS = 64'hFFF8_0000_0000_1000;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [SCC_ADDR_BITS-1:0] paddr;
	logic [SCC_DATA_BITS-1:0] pwdata;
	logic [SCC_DATA_BITS-1:0] prdata;
	logic                     pready;
	int                       mismatches;
	int                       awaited;

	// Idle controls shared by the sender and the receiver process.
	bit sender_gaps   = 1'b0;
	bit receiver_gaps = 1'b0;
	int hold_requests = 0;
	int holds_served  = 0;

	scc_seg_if #(.COORD_BITS(SCC_COORD_BITS)) seg ();
	scc_cls_if cls ();

	segment_crossing_classify #(
		.COORD_BITS(SCC_COORD_BITS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.seg_in  (seg),
		.cls_out (cls),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	segment_crossing_classify_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.seg        (seg),
		.cls        (cls),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.mismatches (mismatches),
		.awaited    (awaited)
	);

	always begin
		#10;
		clk = 1'b1;
		#10;
		clk = 1'b0;
	end

	// The coordinates are truncated to the channel width here, so callers can
	// build pairs with plain integer arithmetic.
	function automatic seg_pair_t make_pair(
		input int aox, input int aoy, input int adx, input int ady,
		input int box, input int boy, input int bdx, input int bdy
	);
		seg_pair_t p;
		p.a_org_x = coord_t'(aox);
		p.a_org_y = coord_t'(aoy);
		p.a_dst_x = coord_t'(adx);
		p.a_dst_y = coord_t'(ady);
		p.b_org_x = coord_t'(box);
		p.b_org_y = coord_t'(boy);
		p.b_dst_x = coord_t'(bdx);
		p.b_dst_y = coord_t'(bdy);
		return p;
	endfunction

	function automatic int rand_span(input int lim);
		return int'($urandom_range(0, 2 * lim)) - lim;
	endfunction

	// Full-range coordinate, leaning on the extremes and the sign boundary.
	function automatic int rand_coord();
		int c;
		case ($urandom_range(0, 7))
			0: c = COORD_LO;
			1: c = COORD_HI;
			2: c = 0;
			3: c = -1;
			default: c = int'($urandom);
		endcase
		return c;
	endfunction

	// Random pair shaped so that every class comes up often. Unrelated
	// full-range segments almost never have parallel directions, so about a
	// fifth of the pairs put B on a line parallel to A, sometimes exactly on
	// line A and sometimes a little off it, where the tolerance decides.
	function automatic seg_pair_t random_pair();
		seg_pair_t p;
		int        c[8];
		int        ax, ay, dx, dy, k, m, ox, oy, qx, qy;
		int        pick_x, pick_y;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				for (int i = 0; i < 8; i++) c[i] = rand_coord();
				p = make_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
			end
			3, 4: begin
				// Small coordinates: a lattice dense enough for lucky parallels.
				for (int i = 0; i < 8; i++) c[i] = rand_span(64);
				p = make_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
			end
			5, 6: begin
				ax = rand_span(1 << 22);
				ay = rand_span(1 << 22);
				dx = rand_span(1024);
				dy = rand_span(1024);
				k  = rand_span(256);
				m  = rand_span(256);
				if ($urandom_range(0, 1) == 0) begin
					ox = 0;
					oy = 0;
				end else begin
					ox = rand_span(8);
					oy = rand_span(8);
				end
				p = make_pair(ax, ay, ax + dx, ay + dy,
					ax + k * dx + ox, ay + k * dy + oy,
					ax + (k + m) * dx + ox, ay + (k + m) * dy + oy);
			end
			7, 8: begin
				// One end of B sits on an end of A, so the parameters hit 0 or 1.
				ax = rand_span(1 << 20);
				ay = rand_span(1 << 20);
				dx = rand_span(1 << 20);
				dy = rand_span(1 << 20);
				if ($urandom_range(0, 1) == 0) begin
					pick_x = ax;
					pick_y = ay;
				end else begin
					pick_x = ax + dx;
					pick_y = ay + dy;
				end
				qx = pick_x + rand_span(1 << 20);
				qy = pick_y + rand_span(1 << 20);
				if ($urandom_range(0, 1) == 0) begin
					p = make_pair(ax, ay, ax + dx, ay + dy, pick_x, pick_y, qx, qy);
				end else begin
					p = make_pair(ax, ay, ax + dx, ay + dy, qx, qy, pick_x, pick_y);
				end
			end
			default: begin
				// A zero-length segment on one side or the other.
				for (int i = 0; i < 8; i++) c[i] = rand_span(64);
				if ($urandom_range(0, 1) == 0) begin
					p = make_pair(c[0], c[1], c[0], c[1], c[4], c[5], c[6], c[7]);
				end else begin
					p = make_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[4], c[5]);
				end
			end
		endcase
		return p;
	endfunction

	// Called and returning at a falling edge. A random idle burst may come
	// first; the pair then stays on the channel until the block accepts it.
	task automatic send_pair(input seg_pair_t p);
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			seg.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		seg.valid   <= 1'b1;
		seg.a_org_x <= p.a_org_x;
		seg.a_org_y <= p.a_org_y;
		seg.a_dst_x <= p.a_dst_x;
		seg.a_dst_y <= p.a_dst_y;
		seg.b_org_x <= p.b_org_x;
		seg.b_org_y <= p.b_org_y;
		seg.b_dst_x <= p.b_dst_x;
		seg.b_dst_y <= p.b_dst_y;
		@(posedge clk);
		while (!seg.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++) send_pair(random_pair());
	endtask

	// Stop offering beats and wait until every class has come back, then
	// let the pipeline settle so any stray beat would show up.
	task automatic drain_results();
		seg.valid <= 1'b0;
		while (awaited != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the data at the
	// rising edge where the access phase sees pready.
	task automatic apb_write(
		input logic [SCC_ADDR_BITS-1:0] addr,
		input logic [SCC_DATA_BITS-1:0] data
	);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Result side. A hold-off request takes priority and keeps ready low for
	// a long stretch counted here, so the sender fills the pipeline and sees
	// seg_in.ready drop. Otherwise ready stalls in random bursts when enabled.
	initial begin : result_ready
		cls.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != holds_served) begin
				cls.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds_served++;
				cls.ready <= 1'b1;
			end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
				cls.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				cls.ready <= 1'b1;
			end else begin
				cls.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		seg_pair_t directed[$];
		seg_pair_t far_offset;
		seg_pair_t point_off_line;

		arst_n      = 1'b0;
		seg.valid   = 1'b0;
		seg.a_org_x = '0;
		seg.a_org_y = '0;
		seg.a_dst_x = '0;
		seg.a_dst_y = '0;
		seg.b_org_x = '0;
		seg.b_org_y = '0;
		seg.b_dst_x = '0;
		seg.b_dst_y = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;

		// B is a single point at the far corner, off the main diagonal A by
		// the largest cross product the coordinates allow.
		far_offset = make_pair(COORD_LO, COORD_LO, COORD_HI, COORD_HI,
			COORD_HI, COORD_LO, COORD_HI, COORD_LO);
		// B is a single point a short distance off line A.
		point_off_line = make_pair(0, 0, 10, 0, 3, 4, 3, 4);

		// Both segments of zero length: collinear.
		directed = {directed, make_pair(0, 0, 0, 0, 0, 0, 0, 0)};
		// Full-range diagonals crossing in the middle, in both orientations.
		directed = {directed, make_pair(COORD_LO, COORD_LO, COORD_HI, COORD_HI,
			COORD_LO, COORD_HI, COORD_HI, COORD_LO)};
		directed = {directed, make_pair(COORD_HI, COORD_HI, COORD_LO, COORD_LO,
			COORD_HI, COORD_LO, COORD_LO, COORD_HI)};
		// Full-range horizontal segments at opposite edges: parallel.
		directed = {directed, make_pair(COORD_LO, COORD_LO, COORD_HI, COORD_LO,
			COORD_LO, COORD_HI, COORD_HI, COORD_HI)};
		// On one line, overlapping and apart: both collinear.
		directed = {directed, make_pair(COORD_LO, 0, 0, 0, COORD_HI, 0, -5, 0)};
		directed = {directed, make_pair(0, 0, 10, 0, 20, 0, 30, 0)};
		// End touches: B starts at A's end, and B ends at A's start.
		directed = {directed, make_pair(0, 0, 10, 0, 10, 0, 10, 10)};
		directed = {directed, make_pair(0, 0, 10, 0, 0, -5, 0, 0)};
		// B ends in the middle of A.
		directed = {directed, make_pair(0, 0, 10, 0, 5, 5, 5, 0)};
		// Skew but missing: past A's end, and short of A from above and below;
		// all three have a negative denominator.
		directed = {directed, make_pair(0, 0, 10, 0, 20, -5, 20, 5)};
		directed = {directed, make_pair(0, 0, 10, 0, 5, 1, 5, 10)};
		directed = {directed, make_pair(0, 0, 10, 0, 5, -5, 5, -1)};
		// Zero-length B off line A and on it.
		directed = {directed, point_off_line};
		directed = {directed, make_pair(0, 0, 10, 0, 3, 0, 3, 0)};
		// Zero-length A is always collinear, wherever B lies.
		directed = {directed, make_pair(7, 7, 7, 7, COORD_LO, COORD_HI, COORD_HI,
			COORD_LO)};
		directed = {directed, make_pair(COORD_HI, COORD_HI, COORD_HI, COORD_HI,
			-1, -1, COORD_LO, COORD_LO)};
		directed = {directed, far_offset};

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed pairs with the reset tolerance of zero, back to back.
		foreach (directed[i]) send_pair(directed[i]);

		// Random pairs with idle bursts on both sides.
		sender_gaps   = 1'b1;
		receiver_gaps = 1'b1;
		send_random(RANDOM_PAIRS);

		// Long receiver hold-off while the sender keeps offering beats.
		sender_gaps = 1'b0;
		hold_requests++;
		send_random(40);
		drain_results();

		// Modest tolerance; the write to the unmapped index must change nothing.
		apb_write(TOL_ADDR, 64'd100);
		apb_write(UNMAPPED_ADDR, '1);
		sender_gaps = 1'b1;
		send_random(RANDOM_PAIRS);
		drain_results();

		// Largest tolerance: every parallel case turns collinear.
		apb_write(TOL_ADDR, TOL_MAX);
		send_pair(far_offset);
		send_pair(point_off_line);
		send_random(100);
		drain_results();

		// Bits above the register width must be dropped by the block.
		apb_write(TOL_ADDR, TOL_WITH_EXCESS);
		send_random(RANDOM_PAIRS);
		drain_results();

		// Last part: tolerance back to zero and no idling at all.
		apb_write(TOL_ADDR, '0);
		sender_gaps   = 1'b0;
		receiver_gaps = 1'b0;
		send_random(RANDOM_PAIRS);
		drain_results();

		if (mismatches == 0 && awaited == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
